/* rtl/bls_pkg.sv */
`default_nettype none

package bls_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned POSITION_W = 9;
   localparam int unsigned COUNT_W    = 9;
   localparam int unsigned DEPTH_W    = 9;

   localparam int unsigned MAX_DEPTH_DEFAULT = 256;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 9'd256;

   // returned for push, for any error and as the top of an empty stack
   localparam logic signed [WORD_W-1:0] WORD_NONE = -32'sd1;

   typedef enum logic [1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_POP  = 2'd1,
      FUNC_PEEK = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_OVERFLOW     = 2'd1,
      STATUS_UNDERFLOW    = 2'd2,
      STATUS_BAD_POSITION = 2'd3
   } status_type;

   typedef struct packed {
      func_type                 func;
      logic signed [WORD_W-1:0] push_value;
      logic [POSITION_W-1:0]    position;
   } bls_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] read_value;
      status_type               status;
      logic signed [WORD_W-1:0] top_value;
      logic                     is_empty;
      logic                     is_full;
      logic [COUNT_W-1:0]       entry_count;
   } bls_rsp_type;

   // item between accept and the output register; a word may still be due from memory
   typedef struct packed {
      logic signed [WORD_W-1:0] read_value;
      logic                     read_from_mem;
      status_type               status;
      logic signed [WORD_W-1:0] top_value;
      logic                     top_from_mem;
      logic                     is_empty;
      logic                     is_full;
      logic [COUNT_W-1:0]       entry_count;
   } bls_stage_type;

endpackage

`default_nettype wire

/* rtl/bounded_lifo_stack_core.sv */
`default_nettype none

// Bounded LIFO stack of signed 32-bit words.
// Request channel (req_valid / req_stall / req_data): each item is a push, a pop
// or a peek at a 1-based position from the top. An item is taken at a clock
// edge with req_valid high and req_stall low.
// Response channel (rsp_valid / rsp_stall / rsp_data): one item per request,
// in order, carrying the read word, a status code, the top word, the empty and
// full flags and the entry count after the operation.
// csr_we / csr_wdata set the depth in use; write it only while the block is idle.
// A taken request passes through the internal stage and then the output
// register to rsp_data. Throughput: one item per cycle while rsp_stall is low.
// Each item touches the entry memory at most once, through its single write
// port or its single registered read port; the top word is held in a register
// so that pop and peek need no second read.
// Reset empties the stack and sets the depth in use to 256; entry contents are
// left as they were. While rsp_stall is high the response holds and one more
// item may be taken into the internal stage, after which req_stall rises.
module bounded_lifo_stack_core #(
   parameter int unsigned MAX_DEPTH = bls_pkg::MAX_DEPTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [bls_pkg::DEPTH_W-1:0] csr_wdata,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire bls_pkg::bls_req_type        req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output bls_pkg::bls_rsp_type             rsp_data
);
   import bls_pkg::*;

   localparam int unsigned ADDR_W = $clog2(MAX_DEPTH);

   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bls_rsp_type        rsp_data_ff, rsp_data_in;

   logic               out_ready;
   logic               out_load;
   bls_rsp_type        out_data;

   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [WORD_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [WORD_W-1:0]  mem_rd_data;

   // depth register: take every write
   assign depth_in = csr_we ? csr_wdata : depth_ff;

   // output register: free when empty or being drained this cycle
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // hold the payload while stalled
   assign rsp_data_in = out_load ? out_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= DEPTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bls_ctrl #(
      .MAX_DEPTH (MAX_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .depth_in_use (depth_ff),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .out_ready    (out_ready),
      .out_load     (out_load),
      .out_data     (out_data),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   bls_mem #(
      .DEPTH  (MAX_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

`ifndef SYNTHESIS
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while stalled");

   a_stall_blocks_on_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("request stalled with the output free");

   a_empty_top_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_empty) |-> rsp_data.top_value == WORD_NONE)
      else $error("empty stack shows a top word");
`endif

endmodule

`default_nettype wire

/* rtl/bls_mem.sv */
`default_nettype none

module bls_mem #(
   parameter int unsigned DEPTH  = bls_pkg::MAX_DEPTH_DEFAULT,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [bls_pkg::WORD_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic      [bls_pkg::WORD_W-1:0] rd_data
);
   import bls_pkg::*;

   logic [WORD_W-1:0] entry_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/bls_ctrl.sv */
`default_nettype none

module bls_ctrl #(
   parameter int unsigned MAX_DEPTH = bls_pkg::MAX_DEPTH_DEFAULT,
   parameter int unsigned ADDR_W    = $clog2(MAX_DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [bls_pkg::DEPTH_W-1:0] depth_in_use,
   input  wire logic                        req_valid,
   input  wire bls_pkg::bls_req_type        req_data,
   output logic                             req_stall,
   input  wire logic                        out_ready,
   output logic                             out_load,
   output bls_pkg::bls_rsp_type             out_data,
   output logic                             mem_wr_en,
   output logic [ADDR_W-1:0]                mem_wr_addr,
   output logic [bls_pkg::WORD_W-1:0]       mem_wr_data,
   output logic                             mem_rd_en,
   output logic [ADDR_W-1:0]                mem_rd_addr,
   input  wire logic [bls_pkg::WORD_W-1:0]  mem_rd_data
);
   import bls_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_DEPTH + 1);
   localparam int unsigned CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [WORD_W-1:0] top_ff, top_in;
   logic                     top_sel_ff, top_sel_in;
   logic                     stage_valid_ff, stage_valid_in;
   bls_stage_type            stage_ff, stage_in;

   logic                     accept;
   logic signed [WORD_W-1:0] top_now;
   logic [CMP_W-1:0]         count_ext, depth_ext, pos_ext, eff_depth, peek_diff;
   logic [CNT_W-1:0]         pop_diff;

   assign count_ext = CMP_W'(count_ff);
   assign depth_ext = CMP_W'(depth_in_use);
   assign pos_ext   = CMP_W'(req_data.position);
   assign peek_diff = count_ext - pos_ext;
   assign pop_diff  = count_ff - CNT_W'(2);

   always_comb begin
      if (depth_ext == '0) begin
         eff_depth = CMP_W'(1);
      end else if (depth_ext > CMP_W'(MAX_DEPTH)) begin
         eff_depth = CMP_W'(MAX_DEPTH);
      end else begin
         eff_depth = depth_ext;
      end
   end

   // after a pop that leaves entries, the new top comes from the registered memory read data in the next cycle
   assign top_now   = top_sel_ff ? signed'(mem_rd_data) : top_ff;
   assign req_stall = stage_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;
   assign out_load  = stage_valid_ff && out_ready;

   always_comb begin
      count_in    = count_ff;
      top_in      = top_ff;
      top_sel_in  = top_sel_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[ADDR_W-1:0];
      mem_wr_data = req_data.push_value;
      mem_rd_en   = 1'b0;
      mem_rd_addr = pop_diff[ADDR_W-1:0];
      stage_in    = stage_ff;
      if (accept) begin
         top_in                 = top_now;
         top_sel_in             = 1'b0;
         stage_in.read_value    = WORD_NONE;
         stage_in.read_from_mem = 1'b0;
         stage_in.status        = STATUS_OK;
         case (req_data.func)
            FUNC_PUSH: begin
               if (count_ext >= eff_depth) begin
                  stage_in.status = STATUS_OVERFLOW;
               end else begin
                  mem_wr_en = 1'b1;
                  count_in  = CNT_W'(count_ff + 1'b1);
                  top_in    = req_data.push_value;
               end
            end
            FUNC_POP: begin
               if (count_ff == '0) begin
                  stage_in.status = STATUS_UNDERFLOW;
               end else begin
                  stage_in.read_value = top_now;
                  count_in            = CNT_W'(count_ff - 1'b1);
                  if (count_ff > CNT_W'(1)) begin
                     mem_rd_en  = 1'b1;
                     top_sel_in = 1'b1;
                  end
               end
            end
            FUNC_PEEK: begin
               if (pos_ext == '0 || pos_ext > count_ext) begin
                  stage_in.status = STATUS_BAD_POSITION;
               end else if (pos_ext == CMP_W'(1)) begin
                  stage_in.read_value = top_now;
               end else begin
                  mem_rd_en              = 1'b1;
                  mem_rd_addr            = peek_diff[ADDR_W-1:0];
                  stage_in.read_from_mem = 1'b1;
               end
            end
            default: begin
            end
         endcase
         stage_in.top_value    = (count_in == '0) ? WORD_NONE : top_in;
         stage_in.top_from_mem = top_sel_in;
         stage_in.is_empty     = (count_in == '0);
         stage_in.is_full      = (CMP_W'(count_in) >= eff_depth);
         stage_in.entry_count  = COUNT_W'(count_in);
      end
   end

   always_comb begin
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (out_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         top_sel_ff     <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         top_sel_ff     <= top_sel_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff   <= top_in;
      stage_ff <= stage_in;
   end

   // merge the word read from memory into the item
   always_comb begin
      out_data.read_value  = stage_ff.read_from_mem ? signed'(mem_rd_data) : stage_ff.read_value;
      out_data.status      = stage_ff.status;
      out_data.top_value   = stage_ff.top_from_mem ? signed'(mem_rd_data) : stage_ff.top_value;
      out_data.is_empty    = stage_ff.is_empty;
      out_data.is_full     = stage_ff.is_full;
      out_data.entry_count = stage_ff.entry_count;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DEPTH))
      else $error("entry count beyond memory depth");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid_ff)
      else $error("request stalled with no item in flight");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.func == FUNC_PUSH && count_ext < eff_depth)
      |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("push did not advance the count");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.func == FUNC_POP && count_ff != '0)
      |=> count_ff == CNT_W'($past(count_ff) - 1'b1))
      else $error("pop did not drop the count");

   a_mem_ports_apart: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("read and write issued for one item");
`endif

endmodule

`default_nettype wire
